// ===== rtl/bfw_pkg.sv =====
package bfw_pkg;

  localparam int unsigned BLOCK_BYTES = 256;
  localparam int unsigned BUF_DEPTH   = 256;
  localparam int unsigned BUF_AW      = 8;
  localparam int unsigned CNT_W       = 9;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_WRITTEN = 2'd1;
  localparam logic [1:0] ST_FAILED  = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  // What the output stage does with its checksum register and tx byte.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LIT,   // send literal
    OP_LOAD,  // send literal, checksum = literal
    OP_XLIT,  // send literal, checksum ^= literal
    OP_XMEM,  // send buffer byte (or pad), checksum ^= it
    OP_XOUT,  // send checksum
    OP_CLR    // no send, checksum = 0
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] lit;
    logic       pad;
    logic       taken;
    logic       busy;
    logic [1:0] status;
  } step_t;

endpackage

// ===== rtl/bfw_in_if.sv =====
interface bfw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] byte_in;

  modport source (output valid, cmd, byte_in, input ready);
  modport sink   (input valid, cmd, byte_in, output ready);
endinterface

// ===== rtl/bfw_out_if.sv =====
interface bfw_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       data_taken;
  logic       busy_res;
  logic [1:0] status;

  modport source (output valid, tx_valid, tx_byte, data_taken, busy_res, status,
                  input ready);
  modport sink   (input valid, tx_valid, tx_byte, data_taken, busy_res, status,
                  output ready);
endinterface

// ===== rtl/bfw_block_buf.sv =====
module bfw_block_buf (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [bfw_pkg::BUF_AW-1:0] waddr_i,
  input  logic [7:0]                 wdata_i,
  input  logic                       re_i,
  input  logic [bfw_pkg::BUF_AW-1:0] raddr_i,
  output logic [7:0]                 rdata_o
);

  logic [7:0] mem_q [bfw_pkg::BUF_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bfw_ctrl.sv =====
module bfw_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  logic [2:0]                     cmd_i,
  input  logic [7:0]                     byte_i,
  input  logic                           cfg_we_i,
  input  logic [bfw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bfw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           mem_we_o,
  output logic [bfw_pkg::BUF_AW-1:0]     mem_waddr_o,
  output logic [7:0]                     mem_wdata_o,
  output logic                           mem_re_o,
  output logic [bfw_pkg::BUF_AW-1:0]     mem_raddr_o,
  output bfw_pkg::step_t                 step_o
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_CMD   = 4'd1;
  localparam logic [3:0] PH_ACK1  = 4'd2;
  localparam logic [3:0] PH_ADDR  = 4'd3;
  localparam logic [3:0] PH_ACK2  = 4'd4;
  localparam logic [3:0] PH_COUNT = 4'd5;
  localparam logic [3:0] PH_DATA  = 4'd6;
  localparam logic [3:0] PH_CSUM  = 4'd7;
  localparam logic [3:0] PH_ACK3  = 4'd8;

  localparam logic [2:0] CMD_IMAGE = 3'd0;
  localparam logic [2:0] CMD_END   = 3'd1;
  localparam logic [2:0] CMD_RX    = 3'd2;
  localparam logic [2:0] CMD_TXRDY = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;

  localparam logic [2:0] REG_CMD1    = 3'd0;
  localparam logic [2:0] REG_CMD2    = 3'd1;
  localparam logic [2:0] REG_ACK     = 3'd2;
  localparam logic [2:0] REG_START   = 3'd3;
  localparam logic [2:0] REG_ACK_TO  = 3'd4;
  localparam logic [2:0] REG_BLK_TO  = 3'd5;

  localparam int unsigned CW = bfw_pkg::CNT_W;

  logic [7:0]    cmd1_q, cmd2_q, ack_q;
  logic [31:0]   start_q;
  logic [15:0]   ack_to_q, blk_to_q;

  logic [3:0]    phase_q, phase_d;
  logic [CW-1:0] fill_q, fill_d;   // padded length
  logic [CW-1:0] raw_q, raw_d;     // bytes actually stored
  logic [CW-1:0] sidx_q, sidx_d;
  logic [31:0]   addr_q, addr_d;
  logic [15:0]   wait_q, wait_d;
  logic          spoil_q, spoil_d;
  logic          ending_q, ending_d;

  logic          waiting;
  logic          do_enter, do_fin, fin_ok;
  logic [3:0]    enter_ph;
  logic [CW-1:0] fill_inc, sidx_inc, fill_pad;
  logic [15:0]   wait_inc, limit;
  bfw_pkg::step_t step;

  assign waiting  = (phase_q == PH_ACK1) || (phase_q == PH_ACK2) || (phase_q == PH_ACK3);
  assign fill_inc = fill_q + CW'(1);
  assign sidx_inc = sidx_q + CW'(1);
  assign fill_pad = (fill_q + CW'(3)) & ~CW'(3);
  assign wait_inc = (wait_q != 16'hFFFF) ? wait_q + 16'd1 : wait_q;
  assign limit    = (phase_q == PH_ACK3) ? blk_to_q : ack_to_q;

  assign mem_we_o    = fire_i && (cmd_i == CMD_IMAGE) && (phase_q == PH_IDLE) && !ending_q;
  assign mem_waddr_o = fill_q[bfw_pkg::BUF_AW-1:0];
  assign mem_wdata_o = byte_i;
  assign mem_re_o    = fire_i && (cmd_i == CMD_TXRDY) && (phase_q == PH_DATA);
  assign mem_raddr_o = sidx_q[bfw_pkg::BUF_AW-1:0];

  always_comb begin
    phase_d  = phase_q;
    fill_d   = fill_q;
    raw_d    = raw_q;
    sidx_d   = sidx_q;
    addr_d   = addr_q;
    wait_d   = wait_q;
    spoil_d  = spoil_q;
    ending_d = ending_q;
    do_enter = 1'b0;
    enter_ph = PH_IDLE;
    do_fin   = 1'b0;
    fin_ok   = 1'b0;
    step     = '{op: bfw_pkg::OP_NONE, lit: 8'h00, pad: 1'b0, taken: 1'b0,
                 busy: 1'b0, status: bfw_pkg::ST_NONE};

    if (fire_i) begin
      case (cmd_i)
        CMD_IMAGE: begin
          if (phase_q == PH_IDLE && !ending_q) begin
            fill_d     = fill_inc;
            raw_d      = fill_inc;
            step.taken = 1'b1;
            if (fill_inc >= CW'(bfw_pkg::BLOCK_BYTES)) begin
              do_enter = 1'b1;
              enter_ph = PH_CMD;
            end
          end
        end
        CMD_END: begin
          if (phase_q == PH_IDLE) begin
            if (fill_q == '0) begin
              step.status = bfw_pkg::ST_DONE;
              addr_d      = start_q;
            end else begin
              // pad bytes are not stored; the data phase sends 0xFF past raw
              fill_d   = fill_pad;
              raw_d    = fill_q;
              ending_d = 1'b1;
              do_enter = 1'b1;
              enter_ph = PH_CMD;
            end
          end else begin
            ending_d = 1'b1;
          end
        end
        CMD_RX: begin
          if (waiting) begin
            if (!spoil_q && byte_i == ack_q) begin
              if (phase_q == PH_ACK1) begin
                do_enter = 1'b1;
                enter_ph = PH_ADDR;
              end else if (phase_q == PH_ACK2) begin
                do_enter = 1'b1;
                enter_ph = PH_COUNT;
              end else begin
                do_fin = 1'b1;
                fin_ok = 1'b1;
              end
            end else begin
              spoil_d = 1'b1;
            end
          end
        end
        CMD_TXRDY: begin
          unique case (phase_q)
            PH_CMD: begin
              step.op  = bfw_pkg::OP_LIT;
              step.lit = (sidx_q == '0) ? cmd1_q : cmd2_q;
              sidx_d   = sidx_inc;
              if (sidx_inc >= CW'(2)) begin
                do_enter = 1'b1;
                enter_ph = PH_ACK1;
              end
            end
            PH_ADDR: begin
              if (sidx_q < CW'(4)) begin
                step.op = (sidx_q == '0) ? bfw_pkg::OP_LOAD : bfw_pkg::OP_XLIT;
                case (sidx_q[1:0])
                  2'd0:    step.lit = addr_q[31:24];
                  2'd1:    step.lit = addr_q[23:16];
                  2'd2:    step.lit = addr_q[15:8];
                  default: step.lit = addr_q[7:0];
                endcase
                sidx_d = sidx_inc;
              end else begin
                step.op  = bfw_pkg::OP_XOUT;
                do_enter = 1'b1;
                enter_ph = PH_ACK2;
              end
            end
            PH_COUNT: begin
              step.op  = bfw_pkg::OP_LOAD;
              step.lit = 8'(fill_q - CW'(1));
              do_enter = 1'b1;
              enter_ph = PH_DATA;
            end
            PH_DATA: begin
              step.op  = bfw_pkg::OP_XMEM;
              step.pad = (sidx_q >= raw_q);
              sidx_d   = sidx_inc;
              if (sidx_inc >= fill_q) begin
                do_enter = 1'b1;
                enter_ph = PH_CSUM;
              end
            end
            PH_CSUM: begin
              step.op  = bfw_pkg::OP_XOUT;
              do_enter = 1'b1;
              enter_ph = PH_ACK3;
            end
            default: ;
          endcase
        end
        CMD_TICK: begin
          if (waiting) begin
            wait_d = wait_inc;
            if (wait_inc >= limit) begin
              do_fin = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (do_fin) begin
      if (ending_q) begin
        step.status = fin_ok ? bfw_pkg::ST_DONE : bfw_pkg::ST_FAILED;
        ending_d    = 1'b0;
        addr_d      = start_q;
      end else begin
        step.status = fin_ok ? bfw_pkg::ST_WRITTEN : bfw_pkg::ST_FAILED;
        addr_d      = addr_q + 32'(fill_q);
      end
      fill_d   = '0;
      raw_d    = '0;
      step.op  = bfw_pkg::OP_CLR;
      do_enter = 1'b1;
      enter_ph = PH_IDLE;
    end

    if (do_enter) begin
      phase_d = enter_ph;
      sidx_d  = '0;
      wait_d  = '0;
      spoil_d = 1'b0;
    end

    step.busy = (phase_d != PH_IDLE);

    if (cfg_we_i && cfg_idx_i == REG_START && phase_q == PH_IDLE) begin
      addr_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd1_q   <= 8'h31;
      cmd2_q   <= 8'hCE;
      ack_q    <= 8'h79;
      start_q  <= 32'h0800_0000;
      ack_to_q <= 16'd1000;
      blk_to_q <= 16'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CMD1:   cmd1_q   <= cfg_data_i[7:0];
        REG_CMD2:   cmd2_q   <= cfg_data_i[7:0];
        REG_ACK:    ack_q    <= cfg_data_i[7:0];
        REG_START:  start_q  <= cfg_data_i;
        REG_ACK_TO: ack_to_q <= cfg_data_i[15:0];
        REG_BLK_TO: blk_to_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      fill_q   <= '0;
      raw_q    <= '0;
      sidx_q   <= '0;
      addr_q   <= 32'h0800_0000;
      wait_q   <= '0;
      spoil_q  <= 1'b0;
      ending_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fill_q   <= fill_d;
      raw_q    <= raw_d;
      sidx_q   <= sidx_d;
      addr_q   <= addr_d;
      wait_q   <= wait_d;
      spoil_q  <= spoil_d;
      ending_q <= ending_d;
    end
  end

  assign step_o = step;

endmodule

// ===== rtl/bfw_out.sv =====
module bfw_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  bfw_pkg::step_t step_i,
  input  logic [7:0]     rdata_i,
  output logic           in_ready_o,
  bfw_out_if.source      out_o
);

  logic           v_q, v_d;
  bfw_pkg::step_t step_q;
  logic [7:0]     xor_q, xor_d;
  logic [7:0]     data_byte, tx_byte;
  logic           tx_valid, out_fire;

  assign in_ready_o = !v_q || out_o.ready;
  assign out_fire   = v_q && out_o.ready;
  assign data_byte  = step_q.pad ? 8'hFF : rdata_i;

  always_comb begin
    tx_valid = 1'b1;
    tx_byte  = 8'h00;
    xor_d    = xor_q;
    case (step_q.op)
      bfw_pkg::OP_LIT: tx_byte = step_q.lit;
      bfw_pkg::OP_LOAD: begin
        tx_byte = step_q.lit;
        xor_d   = step_q.lit;
      end
      bfw_pkg::OP_XLIT: begin
        tx_byte = step_q.lit;
        xor_d   = xor_q ^ step_q.lit;
      end
      bfw_pkg::OP_XMEM: begin
        tx_byte = data_byte;
        xor_d   = xor_q ^ data_byte;
      end
      bfw_pkg::OP_XOUT: tx_byte = xor_q;
      bfw_pkg::OP_CLR: begin
        tx_valid = 1'b0;
        xor_d    = 8'h00;
      end
      default: tx_valid = 1'b0;
    endcase
  end

  always_comb begin
    v_d = v_q;
    if (fire_i) begin
      v_d = 1'b1;
    end else if (out_fire) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      xor_q <= 8'h00;
    end else begin
      v_q <= v_d;
      if (out_fire) begin
        xor_q <= xor_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      step_q <= step_i;
    end
  end

  assign out_o.valid      = v_q;
  assign out_o.tx_valid   = tx_valid;
  assign out_o.tx_byte    = tx_byte;
  assign out_o.data_taken = step_q.taken;
  assign out_o.busy_res   = step_q.busy;
  assign out_o.status     = step_q.status;

endmodule

// ===== rtl/bootloader_flash_write_framer_unit.sv =====
// Each accepted word is registered into the result register at the edge that accepts it.
// Throughput: one word per cycle; the input stalls only while a result is held
//   by the output side, as the result register frees when it is taken.
// Reset (rst_ni low, asynchronous): idle, no fill, next address = start, registers
//   at defaults; the block buffer is not cleared and needs no clearing pass.
module bootloader_flash_write_framer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bfw_in_if.sink                         in_i,
  bfw_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [bfw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bfw_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Stage 0 (ctrl): decodes the word, updates phase, counters and address,
  // writes image bytes into the block buffer and issues the buffer read for
  // the data phase.
  // Stage 1 (out): result register; merges the buffer read data, keeps the
  // running XOR so checksum bytes follow the data bytes without a stall.

  logic                       fire;
  logic                       in_ready;
  logic                       mem_we, mem_re;
  logic [bfw_pkg::BUF_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]                 mem_wdata, mem_rdata;
  bfw_pkg::step_t             step;

  assign in_i.ready = in_ready;
  assign fire       = in_i.valid && in_ready;

  bfw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .cmd_i       (in_i.cmd),
    .byte_i      (in_i.byte_in),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .step_o      (step)
  );

  // Block buffer: written only while collecting, read only while sending,
  // so a write and a read of the same entry never overlap.
  bfw_block_buf u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bfw_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .step_i     (step),
    .rdata_i    (mem_rdata),
    .in_ready_o (in_ready),
    .out_o      (out_o)
  );

endmodule

// ===== sim/tb_bootloader_flash_write_framer_unit.sv =====
`timescale 1ns / 1ps

module tb_bootloader_flash_write_framer_unit;

  // Link event codes carried in the cmd field of an input word.
  typedef enum logic [2:0] {
    LW_IMAGE,
    LW_END,
    LW_RX,
    LW_TX_READY,
    LW_TICK,
    LW_RSVD5,
    LW_RSVD6,
    LW_RSVD7
  } link_cmd_e;

  // Configuration register indexes.
  typedef enum logic [bfw_pkg::CFG_IDX_W-1:0] {
    REG_CMD_FIRST,
    REG_CMD_SECOND,
    REG_ACK,
    REG_START_ADDR,
    REG_ACK_TIMEOUT,
    REG_BLOCK_TIMEOUT
  } reg_index_e;

  // Exchange phases of the framer.
  typedef enum logic [3:0] {
    FR_IDLE,
    FR_CMD,
    FR_ACK_CMD,
    FR_ADDR,
    FR_ACK_ADDR,
    FR_COUNT,
    FR_DATA,
    FR_CSUM,
    FR_ACK_DATA
  } frame_phase_e;

  typedef struct packed {
    link_cmd_e  cmd;
    logic [7:0] data;
  } link_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       taken;
    logic       busy;
    logic [1:0] status;
  } framer_result_t;

  localparam int PHASE_WORDS  = 160;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bfw_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [bfw_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  bfw_in_if  in_if ();
  bfw_out_if out_if ();

  bootloader_flash_write_framer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Framer prediction: shadow registers and exchange state
  // ---------------------------------------------------------------------------
  logic [7:0]   cfg_cmd_first, cfg_cmd_second, cfg_ack;
  logic [31:0]  cfg_start;
  logic [15:0]  cfg_ack_to, cfg_blk_to;

  logic [7:0]   img_buf [256];
  logic [8:0]   fill;
  logic [31:0]  addr_next;
  frame_phase_e fr_phase;
  logic [8:0]   snd_idx;
  logic [7:0]   xsum;
  logic [15:0]  tick_cnt;
  logic         spoiled;
  logic         end_pending;

  function automatic void enter_phase(frame_phase_e ph);
    fr_phase = ph;
    snd_idx  = '0;
    tick_cnt = '0;
    spoiled  = 1'b0;
  endfunction

  function automatic void framer_reset();
    cfg_cmd_first  = 8'h31;
    cfg_cmd_second = 8'hCE;
    cfg_ack        = 8'h79;
    cfg_start      = 32'h0800_0000;
    cfg_ack_to     = 16'd1000;
    cfg_blk_to     = 16'd200;
    fill           = '0;
    addr_next      = cfg_start;
    xsum           = '0;
    end_pending    = 1'b0;
    enter_phase(FR_IDLE);
  endfunction

  function automatic void framer_config(reg_index_e idx, logic [31:0] v);
    case (idx)
      REG_CMD_FIRST:     cfg_cmd_first = v[7:0];
      REG_CMD_SECOND:    cfg_cmd_second = v[7:0];
      REG_ACK:           cfg_ack = v[7:0];
      REG_START_ADDR: begin
        cfg_start = v;
        // idle framer picks up the new base at once
        if (fr_phase == FR_IDLE) addr_next = v;
      end
      REG_ACK_TIMEOUT:   cfg_ack_to = v[15:0];
      REG_BLOCK_TIMEOUT: cfg_blk_to = v[15:0];
      default: ;
    endcase
  endfunction

  // Close the running exchange; the address advances even on failure.
  function automatic logic [1:0] close_block(logic ok);
    logic [1:0] st;
    addr_next = addr_next + {23'd0, fill};
    if (end_pending) begin
      st = ok ? bfw_pkg::ST_DONE : bfw_pkg::ST_FAILED;
      end_pending = 1'b0;
      addr_next = cfg_start;
    end else begin
      st = ok ? bfw_pkg::ST_WRITTEN : bfw_pkg::ST_FAILED;
    end
    fill = '0;
    xsum = '0;
    enter_phase(FR_IDLE);
    return st;
  endfunction

  function automatic framer_result_t framer_step(link_cmd_e c, logic [7:0] b);
    framer_result_t r;
    logic           waiting;
    logic [15:0]    limit;
    logic [31:0]    sh;
    logic [8:0]     cnt;
    r = '0;
    waiting = (fr_phase == FR_ACK_CMD) || (fr_phase == FR_ACK_ADDR) ||
              (fr_phase == FR_ACK_DATA);
    case (c)
      LW_IMAGE: begin
        // dropped while an exchange runs or an image end is pending
        if (fr_phase == FR_IDLE && !end_pending) begin
          img_buf[fill[7:0]] = b;
          fill = fill + 9'd1;
          r.taken = 1'b1;
          if (fill >= bfw_pkg::BLOCK_BYTES) enter_phase(FR_CMD);
        end
      end
      LW_END: begin
        if (fr_phase == FR_IDLE) begin
          if (fill == '0) begin
            // nothing left to flush: image complete right away
            r.status = bfw_pkg::ST_DONE;
            addr_next = cfg_start;
          end else begin
            while (fill[1:0] != 2'd0) begin
              img_buf[fill[7:0]] = 8'hFF;
              fill = fill + 9'd1;
            end
            end_pending = 1'b1;
            enter_phase(FR_CMD);
          end
        end else begin
          end_pending = 1'b1;
        end
      end
      LW_RX: begin
        if (waiting) begin
          if (!spoiled && b == cfg_ack) begin
            case (fr_phase)
              FR_ACK_CMD:  enter_phase(FR_ADDR);
              FR_ACK_ADDR: enter_phase(FR_COUNT);
              default:     r.status = close_block(1'b1);
            endcase
          end else begin
            // any other byte spoils the wait; only a timeout ends it now
            spoiled = 1'b1;
          end
        end
      end
      LW_TX_READY: begin
        case (fr_phase)
          FR_CMD: begin
            r.tx_valid = 1'b1;
            r.tx_byte = (snd_idx == '0) ? cfg_cmd_first : cfg_cmd_second;
            snd_idx = snd_idx + 9'd1;
            if (snd_idx >= 9'd2) enter_phase(FR_ACK_CMD);
          end
          FR_ADDR: begin
            r.tx_valid = 1'b1;
            if (snd_idx < 9'd4) begin
              sh = addr_next >> (24 - 8 * snd_idx);
              r.tx_byte = sh[7:0];
              xsum = (snd_idx == '0) ? sh[7:0] : (xsum ^ sh[7:0]);
              snd_idx = snd_idx + 9'd1;
            end else begin
              r.tx_byte = xsum;
              enter_phase(FR_ACK_ADDR);
            end
          end
          FR_COUNT: begin
            r.tx_valid = 1'b1;
            cnt = fill - 9'd1;
            r.tx_byte = cnt[7:0];
            xsum = cnt[7:0];
            enter_phase(FR_DATA);
          end
          FR_DATA: begin
            r.tx_valid = 1'b1;
            r.tx_byte = img_buf[snd_idx[7:0]];
            xsum = xsum ^ r.tx_byte;
            snd_idx = snd_idx + 9'd1;
            if (snd_idx >= fill) enter_phase(FR_CSUM);
          end
          FR_CSUM: begin
            r.tx_valid = 1'b1;
            r.tx_byte = xsum;
            enter_phase(FR_ACK_DATA);
          end
          default: ;
        endcase
      end
      LW_TICK: begin
        if (waiting) begin
          limit = (fr_phase == FR_ACK_DATA) ? cfg_blk_to : cfg_ack_to;
          if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
          if (tick_cnt >= limit) r.status = close_block(1'b0);
        end
      end
      default: ;  // reserved codes do nothing
    endcase
    r.busy = (fr_phase != FR_IDLE);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues, counters and traffic knobs
  // ---------------------------------------------------------------------------
  link_word_t     pend_q [$];      // words waiting for the driver
  framer_result_t expected_q [$];  // predicted result words, oldest first
  link_word_t     drv_word;
  framer_result_t want;
  int words_sent = 0;
  int words_taken = 0;
  int gen_count = 0;
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;

  // what the stimulus side believes the registers hold
  logic [7:0] gen_ack = 8'h79;
  int gen_ack_to = 1000;
  int gen_blk_to = 200;

  // ---------------------------------------------------------------------------
  // Driver: offers the next pending word, idling at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.cmd     <= '0;
      in_if.byte_in <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_word = pend_q.pop_front();
        words_sent++;
        in_if.valid   <= 1'b1;
        in_if.cmd     <= drv_word.cmd;
        in_if.byte_in <= drv_word.data;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random back-pressure on the result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks result words, then predicts for newly accepted words
  // ---------------------------------------------------------------------------
  function automatic void check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, exp_v, act_v);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with no prediction pending");
          err_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("tx_valid", 32'(want.tx_valid), 32'(out_if.tx_valid));
          check_field("tx_byte", 32'(want.tx_byte), 32'(out_if.tx_byte));
          check_field("data_taken", 32'(want.taken), 32'(out_if.data_taken));
          check_field("busy_res", 32'(want.busy), 32'(out_if.busy_res));
          check_field("status", 32'(want.status), 32'(out_if.status));
        end
      end
      if (in_if.valid && in_if.ready) begin
        expected_q = {expected_q, framer_step(link_cmd_e'(in_if.cmd), in_if.byte_in)};
        words_taken++;
      end
      if (cfg_we_i) framer_config(reg_index_e'(cfg_idx_i), cfg_data_i);
    end else begin
      framer_reset();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(link_cmd_e c, logic [7:0] b);
    link_word_t w;
    w.cmd  = c;
    w.data = b;
    pend_q = {pend_q, w};
    gen_count++;
  endtask

  // Register writes; only called with nothing in flight
  task automatic program_regs(logic [31:0] v [6]);
    for (int i = 0; i < 6; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_index_e'(i);
      cfg_data_i <= v[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gen_ack    = v[REG_ACK][7:0];
    gen_ack_to = int'(v[REG_ACK_TIMEOUT][15:0]);
    gen_blk_to = int'(v[REG_BLOCK_TIMEOUT][15:0]);
  endtask

  // Every sent word accepted, every result word seen, then a spare drain wait
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || words_sent != words_taken || expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Stray word; inside an ack wait it never touches the wait itself
  task automatic push_noise(bit in_wait);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    case ($urandom_range(4))
      0: begin
        case ($urandom_range(2))
          0:       push_word(LW_RSVD5, b);
          1:       push_word(LW_RSVD6, b);
          default: push_word(LW_RSVD7, b);
        endcase
      end
      1: push_word(LW_IMAGE, b);
      2: push_word(in_wait ? LW_TX_READY : LW_TICK, b);
      3: push_word(in_wait ? LW_RSVD6 : LW_RX, b);
      default: push_word(($urandom_range(3) == 0) ? LW_END : LW_RSVD7, b);
    endcase
  endtask

  // tx-ready run; a broken exchange loses the odd word
  task automatic send_run(int cnt, bit broken);
    for (int i = 0; i < cnt; i++) begin
      if (!(broken && $urandom_range(19) == 0)) push_word(LW_TX_READY, 8'($urandom_range(255)));
      if ($urandom_range(9) == 0) push_noise(1'b0);
    end
  endtask

  // Ack wait: mostly a clean ack, sometimes a spoiled reply or plain timeout
  task automatic ack_wait(int limit, output bit ok);
    int n;
    ok = 1'b1;
    if (limit <= 40 && $urandom_range(4) == 0) begin
      ok = 1'b0;
      if ($urandom_range(1)) begin
        push_word(LW_RX, gen_ack ^ 8'($urandom_range(1, 255)));
        // an ack after a bad byte no longer counts
        if ($urandom_range(1)) push_word(LW_RX, gen_ack);
      end
      repeat (limit) push_word(LW_TICK, 8'($urandom_range(255)));
    end else begin
      n = (limit > 1) ? $urandom_range(0, (limit - 1 < 3) ? limit - 1 : 3) : 0;
      repeat (n) push_word(LW_TICK, 8'($urandom_range(255)));
      if ($urandom_range(5) == 0) push_noise(1'b1);
      push_word(LW_RX, gen_ack);
    end
  endtask

  // One image (or one full block) and its write exchange
  task automatic gen_exchange(bit full);
    int  n;
    int  len;
    bit  ok;
    bit  broken;
    logic [7:0] b;
    broken = ($urandom_range(9) == 0);
    if (full || $urandom_range(59) == 0) n = bfw_pkg::BLOCK_BYTES;
    else if ($urandom_range(9) == 0) n = 0;
    else n = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(255));
      endcase
      push_word(LW_IMAGE, b);
    end
    if (n < bfw_pkg::BLOCK_BYTES) begin
      push_word(LW_END, 8'($urandom_range(255)));
      if ($urandom_range(7) == 0) push_word(LW_END, 8'($urandom_range(255)));
      if (n == 0) return;
      len = (n + 3) / 4 * 4;
    end else begin
      len = n;
    end
    if (broken && $urandom_range(1)) begin
      repeat ($urandom_range(1, 6))
        push_word(link_cmd_e'($urandom_range(7)), 8'($urandom_range(255)));
    end
    send_run(2, broken);
    ack_wait(gen_ack_to, ok);
    if (!ok) return;
    send_run(5, broken);
    ack_wait(gen_ack_to, ok);
    if (!ok) return;
    send_run(len + 2, broken);  // count, data, checksum
    ack_wait(gen_blk_to, ok);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] regs [6];
    int target;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short timeouts so the directed failure is quick
    regs = '{32'h31, 32'hCE, 32'h79, 32'h0800_0000, 32'd2, 32'd1};
    program_regs(regs);

    push_word(LW_END, 8'h00);        // empty image: done at once
    push_word(LW_RSVD5, 8'hFF);
    push_word(LW_RSVD7, 8'h00);
    push_word(LW_RX, 8'h79);         // stray reply while idle
    push_word(LW_TICK, 8'h00);       // stray tick
    push_word(LW_TX_READY, 8'h00);   // nothing to send
    push_word(LW_IMAGE, 8'h00);
    push_word(LW_IMAGE, 8'hFF);
    push_word(LW_IMAGE, 8'h5A);
    push_word(LW_END, 8'h00);        // pad to 4 and flush
    push_word(LW_TX_READY, 8'h00);
    push_word(LW_IMAGE, 8'hA5);      // dropped while busy
    push_word(LW_END, 8'h00);        // repeated end, no effect
    push_word(LW_TX_READY, 8'h00);
    push_word(LW_RX, 8'h86);         // wrong reply spoils the wait
    push_word(LW_RX, 8'h79);         // ack no longer counts
    push_word(LW_TICK, 8'h00);
    push_word(LW_TICK, 8'h00);       // timeout: last block failed
    push_word(LW_IMAGE, 8'hC3);
    push_word(LW_END, 8'h00);
    push_word(LW_TX_READY, 8'h00);
    push_word(LW_TX_READY, 8'h00);
    push_word(LW_RX, 8'h79);         // command acked
    push_word(LW_TICK, 8'h00);
    push_word(LW_TICK, 8'h00);       // ignored: the address phase is not an ack wait
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: regs = '{32'h31, 32'hCE, 32'h79, 32'h0800_0000, 32'd1000, 32'd200};
        1: regs = '{32'h00, 32'hFF, 32'h00, 32'h0000_0000, 32'd1, 32'd1};
        2: regs = '{32'hFF, 32'h00, 32'hFF, 32'hFFFF_FFFF, 32'd65535, 32'd65535};
        default: begin
          regs[REG_CMD_FIRST]     = $urandom_range(255);
          regs[REG_CMD_SECOND]    = $urandom_range(255);
          regs[REG_ACK]           = $urandom_range(255);
          regs[REG_START_ADDR]    = (p == 5) ? ($urandom | 32'hFFFF_0000) : $urandom;
          regs[REG_ACK_TIMEOUT]   = $urandom_range(2, 24);
          regs[REG_BLOCK_TIMEOUT] = $urandom_range(2, 24);
        end
      endcase
      // sender-light/receiver-heavy idling, then swapped, then none
      send_idle_pct = (p < 2) ? 13 : (p < 4) ? 76 : 0;
      recv_idle_pct = (p < 2) ? 76 : (p < 4) ? 13 : 0;
      program_regs(regs);
      target = gen_count + PHASE_WORDS;
      if (p == 0 || p == 3) gen_exchange(1'b1);  // one full block, not final
      if (p == 5) begin
        // sender stops until the block has answered everything
        while (gen_count < target - PHASE_WORDS / 2) gen_exchange(1'b0);
        wait_drained();
      end
      while (gen_count < target) gen_exchange(1'b0);
      if (p == 4) begin
        // receiver stalls long while the sender keeps offering
        hold_go <= 1'b1;
        @(posedge clk_i);
        hold_go <= 1'b0;
      end
      wait_drained();
    end

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bfw_pkg.sv
rtl/bfw_in_if.sv
rtl/bfw_out_if.sv
rtl/bfw_block_buf.sv
rtl/bfw_ctrl.sv
rtl/bfw_out.sv
rtl/bootloader_flash_write_framer_unit.sv
sim/tb_bootloader_flash_write_framer_unit.sv
